FILE: rtl/gee_pkg.sv
// shared types, constants and helper functions for the gamepad edge event generator
// no dependencies; imported by every module of the block
`default_nettype none

package gee_pkg;

    localparam int NUM_BUTTONS = 14;
    localparam int TABLE_SIZE  = 14;
    localparam int NUM_SCAN    = (NUM_BUTTONS < TABLE_SIZE) ? NUM_BUTTONS : TABLE_SIZE;
    localparam int NUM_KEYS    = 16;
    localparam int KEY_W       = 4;

    localparam logic [KEY_W-1:0] KEY_LEFT_TRIG  = 4'd14;
    localparam logic [KEY_W-1:0] KEY_RIGHT_TRIG = 4'd15;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // register indexes of the configuration port
    localparam logic [1:0] REG_STICK_DEADZONE    = 2'd0;
    localparam logic [1:0] REG_TRIGGER_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_STICK_EPSILON     = 2'd2;
    localparam logic [1:0] REG_TRIGGER_EPSILON   = 2'd3;

    localparam logic [14:0] RST_STICK_DEADZONE    = 15'd5899;
    localparam logic [7:0]  RST_TRIGGER_THRESHOLD = 8'd30;
    localparam logic [14:0] RST_STICK_EPSILON     = 15'd655;
    localparam logic [7:0]  RST_TRIGGER_EPSILON   = 8'd5;

    localparam logic EVENT_KEY    = 1'b0;
    localparam logic EVENT_MOTION = 1'b1;

    // mask bit position of each mapped button, in table order
    localparam logic [3:0] BTN_BIT [TABLE_SIZE] = '{
        4'd12, 4'd13, 4'd14, 4'd15, 4'd8, 4'd9, 4'd6,
        4'd7,  4'd4,  4'd5,  4'd0,  4'd1, 4'd2, 4'd3
    };

    typedef struct packed {
        logic [14:0] stick_deadzone;
        logic [7:0]  trigger_threshold;
        logic [14:0] stick_epsilon;
        logic [7:0]  trigger_epsilon;
    } gee_cfg_t;

    // one classified snapshot waiting to be serialized
    typedef struct packed {
        logic [NUM_KEYS-1:0] key_mask;
        logic [NUM_KEYS-1:0] key_down;
        logic                moved;
        logic signed [15:0]  lx;
        logic signed [15:0]  ly;
        logic signed [15:0]  rx;
        logic signed [15:0]  ry;
        logic [7:0]          lt;
        logic [7:0]          rt;
    } gee_work_t;

    // deadzone, optional negation and symmetric saturation of one stick axis
    function automatic logic signed [15:0] cond_stick(
        input logic signed [15:0] v,
        input logic [14:0]        dz,
        input logic               neg
    );
        logic [16:0]        mag;
        logic signed [15:0] r;
        mag = v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
        if (mag < {2'b00, dz})
            r = 16'sd0;
        else if (v == $signed(16'h8000))
            r = neg ? 16'sd32767 : -16'sd32767;
        else
            r = neg ? -v : v;
        return r;
    endfunction

    function automatic logic stick_moved(
        input logic signed [15:0] a,
        input logic signed [15:0] b,
        input logic [14:0]        eps
    );
        logic [16:0] d;
        logic [16:0] ad;
        d  = {a[15], a} - {b[15], b};
        ad = d[16] ? (17'd0 - d) : d;
        return ad > {2'b00, eps};
    endfunction

    function automatic logic trig_moved(
        input logic [7:0] a,
        input logic [7:0] b,
        input logic [7:0] eps
    );
        logic [8:0] d;
        logic [8:0] ad;
        d  = {1'b0, a} - {1'b0, b};
        ad = d[8] ? (9'd0 - d) : d;
        return ad > {1'b0, eps};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/gee_front.sv
// front part: takes snapshots, conditions sticks, compares with the previous snapshot
// depends on gee_pkg; feeds classified work into gee_queue
`default_nettype none

module gee_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gee_pkg::gee_cfg_t  cfg,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               present,
    input  wire logic [15:0]        button_mask,
    input  wire logic [7:0]         left_trigger,
    input  wire logic [7:0]         right_trigger,
    input  wire logic signed [15:0] left_x,
    input  wire logic signed [15:0] left_y,
    input  wire logic signed [15:0] right_x,
    input  wire logic signed [15:0] right_y,
    output gee_pkg::gee_work_t      work,
    output logic                    work_push,
    input  wire logic               queue_full
);
    import gee_pkg::*;

    // stage 1: registered, conditioned snapshot
    logic               s1_valid_reg, s1_valid_next;
    logic [15:0]        s1_buttons_reg;
    logic [7:0]         s1_lt_reg, s1_rt_reg;
    logic signed [15:0] s1_lx_reg, s1_ly_reg, s1_rx_reg, s1_ry_reg;

    // previous snapshot state
    logic [15:0]        prev_buttons_reg;
    logic               prev_lpress_reg, prev_rpress_reg;
    logic signed [15:0] prev_lx_reg, prev_ly_reg, prev_rx_reg, prev_ry_reg;
    logic [7:0]         prev_lt_reg, prev_rt_reg;

    logic accept, load, advance;
    logic lt_down, rt_down, moved, has_events;
    logic [NUM_KEYS-1:0] key_mask, key_down;

    assign full    = s1_valid_reg && queue_full;
    assign accept  = push && !full;
    assign load    = accept && present;
    assign advance = s1_valid_reg && !queue_full;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (load)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        lt_down  = s1_lt_reg > cfg.trigger_threshold;
        rt_down  = s1_rt_reg > cfg.trigger_threshold;
        key_mask = '0;
        key_down = '0;
        for (int i = 0; i < NUM_SCAN; i++)
        begin
            key_mask[i] = s1_buttons_reg[BTN_BIT[i]] ^ prev_buttons_reg[BTN_BIT[i]];
            key_down[i] = s1_buttons_reg[BTN_BIT[i]];
        end
        key_mask[KEY_LEFT_TRIG]  = lt_down ^ prev_lpress_reg;
        key_down[KEY_LEFT_TRIG]  = lt_down;
        key_mask[KEY_RIGHT_TRIG] = rt_down ^ prev_rpress_reg;
        key_down[KEY_RIGHT_TRIG] = rt_down;
        moved = stick_moved(s1_lx_reg, prev_lx_reg, cfg.stick_epsilon)
             || stick_moved(s1_ly_reg, prev_ly_reg, cfg.stick_epsilon)
             || stick_moved(s1_rx_reg, prev_rx_reg, cfg.stick_epsilon)
             || stick_moved(s1_ry_reg, prev_ry_reg, cfg.stick_epsilon)
             || trig_moved(s1_lt_reg, prev_lt_reg, cfg.trigger_epsilon)
             || trig_moved(s1_rt_reg, prev_rt_reg, cfg.trigger_epsilon);
        has_events = (|key_mask) || moved;
    end

    assign work_push = advance && has_events;

    always_comb
    begin
        work.key_mask = key_mask;
        work.key_down = key_down;
        work.moved    = moved;
        work.lx       = s1_lx_reg;
        work.ly       = s1_ly_reg;
        work.rx       = s1_rx_reg;
        work.ry       = s1_ry_reg;
        work.lt       = s1_lt_reg;
        work.rt       = s1_rt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            prev_buttons_reg <= '0;
            prev_lpress_reg  <= 1'b0;
            prev_rpress_reg  <= 1'b0;
            prev_lx_reg      <= '0;
            prev_ly_reg      <= '0;
            prev_rx_reg      <= '0;
            prev_ry_reg      <= '0;
            prev_lt_reg      <= '0;
            prev_rt_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (advance)
            begin
                prev_buttons_reg <= s1_buttons_reg;
                prev_lpress_reg  <= lt_down;
                prev_rpress_reg  <= rt_down;
                if (moved)
                begin
                    prev_lx_reg <= s1_lx_reg;
                    prev_ly_reg <= s1_ly_reg;
                    prev_rx_reg <= s1_rx_reg;
                    prev_ry_reg <= s1_ry_reg;
                    prev_lt_reg <= s1_lt_reg;
                    prev_rt_reg <= s1_rt_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_buttons_reg <= button_mask;
            s1_lt_reg      <= left_trigger;
            s1_rt_reg      <= right_trigger;
            s1_lx_reg      <= cond_stick(left_x,  cfg.stick_deadzone, 1'b0);
            s1_ly_reg      <= cond_stick(left_y,  cfg.stick_deadzone, 1'b1);
            s1_rx_reg      <= cond_stick(right_x, cfg.stick_deadzone, 1'b0);
            s1_ry_reg      <= cond_stick(right_y, cfg.stick_deadzone, 1'b1);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/gee_queue.sv
// short work queue between the front and back parts
// depends on gee_pkg for the work type and depth
`default_nettype none

module gee_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire gee_pkg::gee_work_t wr_data,
    output logic                    full,
    input  wire logic               rd_en,
    output gee_pkg::gee_work_t      rd_data,
    output logic                    empty
);
    import gee_pkg::*;

    gee_work_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg, count_next;
    logic                  do_wr, do_rd;

    assign full    = count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

FILE: rtl/gee_back.sv
// back part: walks the queued work and emits one event per cycle into the output register
// unless the output stalls; depends on gee_pkg; reads the head of gee_queue
`default_nettype none

module gee_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gee_pkg::gee_work_t head,
    input  wire logic               queue_empty,
    output logic                    queue_pop,
    output logic                    empty,
    input  wire logic               pop,
    output logic                    event_kind,
    output logic [3:0]              key_index,
    output logic                    key_down,
    output logic signed [15:0]      axis_left_x,
    output logic signed [15:0]      axis_left_y,
    output logic signed [15:0]      axis_right_x,
    output logic signed [15:0]      axis_right_y,
    output logic [7:0]              axis_left_trig,
    output logic [7:0]              axis_right_trig,
    output logic                    last
);
    import gee_pkg::*;

    logic [NUM_KEYS-1:0] done_reg, done_next;
    logic                out_valid_reg, out_valid_next;
    logic                kind_reg, down_reg, last_reg;
    logic [KEY_W-1:0]    index_reg;
    logic signed [15:0]  lx_reg, ly_reg, rx_reg, ry_reg;
    logic [7:0]          lt_reg, rt_reg;

    logic [NUM_KEYS-1:0] pending;
    logic [KEY_W-1:0]    sel_idx;
    logic                is_key, single, fire, ev_last;

    always_comb
    begin
        pending = head.key_mask & ~done_reg;
        sel_idx = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--)
        begin
            if (pending[i])
                sel_idx = KEY_W'(i);
        end
        is_key  = |pending;
        single  = (pending & (pending - 1'b1)) == '0;
        ev_last = is_key ? (single && !head.moved) : 1'b1;
    end

    assign fire      = (!out_valid_reg || pop) && !queue_empty;
    assign queue_pop = fire && ev_last;

    always_comb
    begin
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        if (!out_valid_reg || pop)
            out_valid_next = !queue_empty;
        if (fire)
        begin
            if (ev_last)
                done_next = '0;
            else
                done_next = done_reg | (NUM_KEYS'(1) << sel_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            last_reg <= ev_last;
            if (is_key)
            begin
                kind_reg  <= EVENT_KEY;
                index_reg <= sel_idx;
                down_reg  <= head.key_down[sel_idx];
                lx_reg    <= '0;
                ly_reg    <= '0;
                rx_reg    <= '0;
                ry_reg    <= '0;
                lt_reg    <= '0;
                rt_reg    <= '0;
            end
            else
            begin
                kind_reg  <= EVENT_MOTION;
                index_reg <= '0;
                down_reg  <= 1'b0;
                lx_reg    <= head.lx;
                ly_reg    <= head.ly;
                rx_reg    <= head.rx;
                ry_reg    <= head.ry;
                lt_reg    <= head.lt;
                rt_reg    <= head.rt;
            end
        end
    end

    assign empty           = !out_valid_reg;
    assign event_kind      = kind_reg;
    assign key_index       = index_reg;
    assign key_down        = down_reg;
    assign axis_left_x     = lx_reg;
    assign axis_left_y     = ly_reg;
    assign axis_right_x    = rx_reg;
    assign axis_right_y    = ry_reg;
    assign axis_left_trig  = lt_reg;
    assign axis_right_trig = rt_reg;
    assign last            = last_reg;

endmodule

`default_nettype wire

FILE: rtl/gamepad_edge_event_generator.sv
// top level of the gamepad edge event generator: configuration registers and part wiring
// depends on gee_pkg, gee_front, gee_queue and gee_back
`default_nettype none

// channel        direction  handshake              payload
// snapshot       in         push / full            present, button_mask, triggers, sticks
// event          out        pop / empty            event_kind .. last
// configuration  in         cfg_write (no wait)    cfg_index, cfg_data
//
// a snapshot can be taken every cycle while the work queue has room; each one yields
// 0 to 17 events, sent one per cycle by the back part while the output is empty or popped,
// so a snapshot holds the back part until all its events are sent. the first event passes
// the stage register, then the queue, then the output register before it is on the ports.
// a snapshot without a device is dropped at once.
// reset restores register defaults and clears all previous state; full stalls only the input,
// empty/pop only the output, the queue between lets either side stall on its own

module gamepad_edge_event_generator (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // snapshot channel
    input  wire logic               push,
    output logic                    full,
    input  wire logic               present,
    input  wire logic [15:0]        button_mask,
    input  wire logic [7:0]         left_trigger,
    input  wire logic [7:0]         right_trigger,
    input  wire logic signed [15:0] left_x,
    input  wire logic signed [15:0] left_y,
    input  wire logic signed [15:0] right_x,
    input  wire logic signed [15:0] right_y,
    // event channel
    output logic                    empty,
    input  wire logic               pop,
    output logic                    event_kind,
    output logic [3:0]              key_index,
    output logic                    key_down,
    output logic signed [15:0]      axis_left_x,
    output logic signed [15:0]      axis_left_y,
    output logic signed [15:0]      axis_right_x,
    output logic signed [15:0]      axis_right_y,
    output logic [7:0]              axis_left_trig,
    output logic [7:0]              axis_right_trig,
    output logic                    last,
    // configuration write port
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [14:0]        cfg_data
);
    import gee_pkg::*;

    gee_cfg_t  cfg_reg, cfg_next;
    gee_work_t work_in, work_head;
    logic      work_push, q_full, q_empty, q_pop;

    // register file; the user must write it only while the block is idle, the block does not enforce it
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_STICK_DEADZONE:    cfg_next.stick_deadzone    = cfg_data;
                REG_TRIGGER_THRESHOLD: cfg_next.trigger_threshold = cfg_data[7:0];
                REG_STICK_EPSILON:     cfg_next.stick_epsilon     = cfg_data;
                REG_TRIGGER_EPSILON:   cfg_next.trigger_epsilon   = cfg_data[7:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stick_deadzone    <= RST_STICK_DEADZONE;
            cfg_reg.trigger_threshold <= RST_TRIGGER_THRESHOLD;
            cfg_reg.stick_epsilon     <= RST_STICK_EPSILON;
            cfg_reg.trigger_epsilon   <= RST_TRIGGER_EPSILON;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: conditioning and edge detection against the previous snapshot
    gee_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .push          (push),
        .full          (full),
        .present       (present),
        .button_mask   (button_mask),
        .left_trigger  (left_trigger),
        .right_trigger (right_trigger),
        .left_x        (left_x),
        .left_y        (left_y),
        .right_x       (right_x),
        .right_y       (right_y),
        .work          (work_in),
        .work_push     (work_push),
        .queue_full    (q_full)
    );

    // decoupling queue of classified snapshots
    gee_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (work_push),
        .wr_data (work_in),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (work_head),
        .empty   (q_empty)
    );

    // back: one event per cycle into the output register unless the output stalls
    gee_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (work_head),
        .queue_empty     (q_empty),
        .queue_pop       (q_pop),
        .empty           (empty),
        .pop             (pop),
        .event_kind      (event_kind),
        .key_index       (key_index),
        .key_down        (key_down),
        .axis_left_x     (axis_left_x),
        .axis_left_y     (axis_left_y),
        .axis_right_x    (axis_right_x),
        .axis_right_y    (axis_right_y),
        .axis_left_trig  (axis_left_trig),
        .axis_right_trig (axis_right_trig),
        .last            (last)
    );

    // queue can never report full and empty together
    assert property (@(posedge clk) disable iff (!rst_n) !(q_full && q_empty))
        else $error("work queue full and empty at once");

    // a taken event is replaced at once when the queue holds more work
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !q_empty) |=> !empty)
        else $error("output register not refilled from pending work");

    // the queue is only popped when an event is moved into the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (!q_empty && (empty || pop)))
        else $error("queue popped without an event transaction");

    // a threshold write lands in its register
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && cfg_index == REG_TRIGGER_THRESHOLD)
        |=> cfg_reg.trigger_threshold == $past(cfg_data[7:0]))
        else $error("trigger threshold write lost");

endmodule

`default_nettype wire
